/* rtl/core/dufc_pkg.sv */
// Shared types, constants and helper functions for the date/user Feistel cipher.
package dufc_pkg;

  localparam int unsigned HalfW   = 19;
  localparam int unsigned TokenW  = 2 * HalfW;
  localparam int unsigned UserW   = 18;
  localparam int unsigned Rounds  = 4;
  localparam int unsigned NumKeys = 4;
  localparam int unsigned KeyIdxW = $clog2(NumKeys);

  // Round function constants
  localparam logic [31:0] MixAdd = 32'h9e3779b9;
  localparam logic [31:0] MixMul = 32'h85ebca6b;

  typedef enum logic {
    OpEncrypt = 1'b0,
    OpDecrypt = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ErrNone = 2'd0,
    ErrDate = 2'd1,
    ErrUser = 2'd2
  } err_e;

  typedef struct packed {
    op_e          opcode;
    logic [3:0]   month_in;
    logic [4:0]   day_in;
    logic [4:0]   hour_in;
    logic [5:0]   minute_in;
    logic [7:0]   user_char_a;
    logic [7:0]   user_char_b;
    logic [7:0]   user_char_c;
    logic [37:0]  cipher_in;
  } req_t;

  typedef struct packed {
    logic [37:0]  cipher_out;
    logic [3:0]   month_out;
    logic [4:0]   day_out;
    logic [4:0]   hour_out;
    logic [5:0]   minute_out;
    logic [7:0]   user_out_a;
    logic [7:0]   user_out_b;
    logic [7:0]   user_out_c;
    err_e         error_code;
  } rsp_t;

  // Base64 index of an ASCII code; bit 6 set means outside the alphabet
  function automatic logic [6:0] b64_index(input logic [7:0] c);
    logic [6:0] res;
    if (c >= 8'h41 && c <= 8'h5a) begin
      res = {1'b0, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      res = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      res = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2b) begin
      res = {1'b0, 6'd62};
    end else if (c == 8'h2f) begin
      res = {1'b0, 6'd63};
    end else begin
      res = 7'h40;
    end
    return res;
  endfunction

  // ASCII code of a Base64 index
  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    logic [7:0] res;
    if (idx < 6'd26) begin
      res = 8'h41 + {2'b00, idx};
    end else if (idx < 6'd52) begin
      res = 8'h61 + {2'b00, idx} - 8'd26;
    end else if (idx < 6'd62) begin
      res = 8'h30 + {2'b00, idx} - 8'd52;
    end else if (idx == 6'd62) begin
      res = 8'h2b;
    end else begin
      res = 8'h2f;
    end
    return res;
  endfunction

  // First half of the round function: key xor, constant add and first xor-shift
  function automatic logic [31:0] mix_pre(input logic [HalfW-1:0] half,
                                          input logic [HalfW-1:0] key);
    logic [31:0] m;
    m = {{(32-HalfW){1'b0}}, half ^ key} + MixAdd;
    return m ^ (m >> 10);
  endfunction

  // Last step of the round function after the multiply
  function automatic logic [HalfW-1:0] mix_fin(input logic [31:0] p);
    logic [31:0] m;
    m = p ^ (p >> 8);
    return m[HalfW-1:0];
  endfunction

endpackage

/* rtl/core/datetime_user_feistel_cipher_unit.sv */
// Top level of the date/user Feistel cipher: pipelined encrypt and decrypt.
//
// Usage:
//   Request channel (req_valid_i / req_ready_o / req_i) carries one opcode
//   plus the date, user and ciphertext fields. Encrypt checks and packs the
//   date and user fields into a 38-bit token and runs the Feistel rounds;
//   decrypt runs the rounds backwards and unpacks raw fields.
//   Response channel (rsp_valid_o / rsp_ready_i / rsp_o) returns one result
//   per request, in order. Failed checks give an error code and zero fields.
//   Round keys are written through cfg_we_i / cfg_idx_i / cfg_data_i; the
//   user must write them only while no request is in flight, and the
//   block itself does not enforce this. A request passes the input stage,
//   which loads on the accepting edge, a pre-mix and a multiply stage per
//   round and the response register between accept and response valid.
//   Throughput is one request per cycle while the receiver does not stall;
//   each round's 32x32 multiply has its own stage.
//   When the receiver stalls, the whole pipeline holds and req_ready_o
//   drops; nothing is lost or repeated. Reset clears all valid bits and
//   sets every round key to zero.
module datetime_user_feistel_cipher_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   req_valid_i,
  output logic                                   req_ready_o,
  input  dufc_pkg::req_t                         req_i,
  output logic                                   rsp_valid_o,
  input  logic                                   rsp_ready_i,
  output dufc_pkg::rsp_t                         rsp_o,
  input  logic                                   cfg_we_i,
  input  logic [dufc_pkg::KeyIdxW-1:0]           cfg_idx_i,
  input  logic [dufc_pkg::HalfW-1:0]             cfg_data_i
);

  localparam int unsigned NumStg = 2 * dufc_pkg::Rounds + 1;
  localparam int unsigned HW     = dufc_pkg::HalfW;

  // Round keys
  logic [HW-1:0] key_q [dufc_pkg::NumKeys];

  // Pipeline stage registers: stage 0 is input, then pre-mix/multiply pairs
  logic              vld_q [NumStg];
  dufc_pkg::op_e     op_q  [NumStg];
  dufc_pkg::err_e    err_q [NumStg];
  logic [HW-1:0]     a_q   [NumStg];
  logic [HW-1:0]     b_q   [NumStg];
  logic [31:0]       mix_q [1:NumStg-1];

  logic [HW-1:0]     a_d   [NumStg];
  logic [HW-1:0]     b_d   [NumStg];
  logic [31:0]       mix_d [1:NumStg-1];
  logic [HW-1:0]     a_in_d;
  logic [HW-1:0]     b_in_d;
  dufc_pkg::err_e    err_d;

  logic              rsp_valid_q;
  dufc_pkg::rsp_t    rsp_q;
  dufc_pkg::rsp_t    rsp_d;
  logic              adv;

  // Whole pipeline moves when the response register is free or drained
  assign adv         = !rsp_valid_q || rsp_ready_i;
  assign req_ready_o = adv;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // Key register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < dufc_pkg::NumKeys; k++) begin
        key_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      key_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Input stage: field checks, Base64 lookup, packing into the (a, b) pair.
  // a is the half fed to the round function, b the half it is xored into.
  always_comb begin
    logic [6:0]               ia;
    logic [6:0]               ib;
    logic [6:0]               ic;
    logic                     date_ok;
    logic [dufc_pkg::TokenW-1:0] pk;
    ia = dufc_pkg::b64_index(req_i.user_char_a);
    ib = dufc_pkg::b64_index(req_i.user_char_b);
    ic = dufc_pkg::b64_index(req_i.user_char_c);
    date_ok = (req_i.month_in >= 4'd1) && (req_i.month_in <= 4'd12) &&
              (req_i.day_in != 5'd0) && (req_i.hour_in <= 5'd23) &&
              (req_i.minute_in <= 6'd59);
    pk = {req_i.month_in, req_i.day_in, req_i.hour_in, req_i.minute_in,
          ia[5:0], ib[5:0], ic[5:0]};
    if (req_i.opcode == dufc_pkg::OpDecrypt) begin
      err_d  = dufc_pkg::ErrNone;
      a_in_d = req_i.cipher_in[2*HW-1:HW];
      b_in_d = req_i.cipher_in[HW-1:0];
    end else begin
      if (!date_ok) begin
        err_d = dufc_pkg::ErrDate;
      end else if (ia[6] || ib[6] || ic[6]) begin
        err_d = dufc_pkg::ErrUser;
      end else begin
        err_d = dufc_pkg::ErrNone;
      end
      a_in_d = pk[HW-1:0];
      b_in_d = pk[2*HW-1:HW];
    end
  end

  // Round stages: pre-mix (with previous round's finish), then multiply
  always_comb begin
    int unsigned    ki;
    logic [HW-1:0]  key;
    logic [HW-1:0]  na;
    logic [HW-1:0]  nb;
    a_d[0] = a_in_d;
    b_d[0] = b_in_d;
    for (int r = 0; r < dufc_pkg::Rounds; r++) begin
      if (op_q[2*r] == dufc_pkg::OpDecrypt) begin
        ki = (dufc_pkg::Rounds - 1 - r) % dufc_pkg::NumKeys;
      end else begin
        ki = r % dufc_pkg::NumKeys;
      end
      key = key_q[ki[dufc_pkg::KeyIdxW-1:0]];
      if (r == 0) begin
        na = a_q[0];
        nb = b_q[0];
      end else begin
        na = b_q[2*r] ^ dufc_pkg::mix_fin(mix_q[2*r]);
        nb = a_q[2*r];
      end
      a_d[2*r+1]   = na;
      b_d[2*r+1]   = nb;
      mix_d[2*r+1] = dufc_pkg::mix_pre(na, key);
      a_d[2*r+2]   = a_q[2*r+1];
      b_d[2*r+2]   = b_q[2*r+1];
      mix_d[2*r+2] = mix_q[2*r+1] * dufc_pkg::MixMul;
    end
  end

  // Output stage: last round finish, unpack and format
  always_comb begin
    logic [HW-1:0]               fa;
    logic [HW-1:0]               fb;
    logic [dufc_pkg::TokenW-1:0] tok;
    fa = b_q[NumStg-1] ^ dufc_pkg::mix_fin(mix_q[NumStg-1]);
    fb = a_q[NumStg-1];
    rsp_d = '0;
    rsp_d.error_code = err_q[NumStg-1];
    if (op_q[NumStg-1] == dufc_pkg::OpDecrypt) begin
      tok = {fa, fb};
      rsp_d.month_out  = tok[37:34];
      rsp_d.day_out    = tok[33:29];
      rsp_d.hour_out   = tok[28:24];
      rsp_d.minute_out = tok[23:18];
      rsp_d.user_out_a = dufc_pkg::b64_char(tok[17:12]);
      rsp_d.user_out_b = dufc_pkg::b64_char(tok[11:6]);
      rsp_d.user_out_c = dufc_pkg::b64_char(tok[5:0]);
    end else begin
      tok = {fb, fa};
      if (err_q[NumStg-1] == dufc_pkg::ErrNone) begin
        rsp_d.cipher_out = tok;
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NumStg; s++) begin
        vld_q[s] <= 1'b0;
      end
      rsp_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= req_valid_i;
      for (int s = 1; s < NumStg; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
      rsp_valid_q <= vld_q[NumStg-1];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      op_q[0]  <= req_i.opcode;
      err_q[0] <= err_d;
      for (int s = 0; s < NumStg; s++) begin
        a_q[s] <= a_d[s];
        b_q[s] <= b_d[s];
      end
      for (int s = 1; s < NumStg; s++) begin
        op_q[s]  <= op_q[s-1];
        err_q[s] <= err_q[s-1];
        mix_q[s] <= mix_d[s];
      end
      if (vld_q[NumStg-1]) begin
        rsp_q <= rsp_d;
      end
    end
  end

endmodule
